>>> src/swl_pkg.sv
// Shared types and constants for the sliding-window weight limiter.
// No dependencies; swl_ctrl, the core and the checker in src use it by scoped names.
package swl_pkg;

	localparam int LOG_ENTRIES_DEF = 16;
	localparam int TIME_W          = 32;
	localparam int WEIGHT_W        = 8;
	localparam int LIMIT_W         = 16;
	localparam int TOTAL_FIELD_W   = 12;
	localparam int TOTAL_FIELD_MAX = 4095;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 32;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd100;
	localparam logic [TIME_W-1:0]  WINDOW_RESET = 32'd60000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT_LIMIT = 1'b0,
		REG_WINDOW_MS    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_ALLOWED    = 2'd0,
		ST_OVER_LIMIT = 2'd1,
		ST_LOG_FULL   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_DECIDE
	} state_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] weight_limit;
		logic [TIME_W-1:0]  window_ms;
	} cfg_t;

endpackage

>>> src/swl_log_mem.sv
// Log storage: one synchronous RAM holding {timestamp, weight} per slot.
// One write port and one read port with registered read data. Uses no package.
module swl_log_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 40
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> src/swl_ctrl.sv
// Scan sequencer: sweeps the log RAM one slot a cycle, expires old entries,
// sums weights, finds the lowest free slot, then decides and logs. Uses swl_pkg.
module swl_ctrl #(
	parameter int LOG_ENTRIES = swl_pkg::LOG_ENTRIES_DEF,
	parameter int IDX_W       = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swl_pkg::cfg_t                   cfg,
	input  logic                            start,
	output logic                            busy,
	input  logic [swl_pkg::TIME_W-1:0]      now_ms,
	input  logic [swl_pkg::WEIGHT_W-1:0]    weight,
	output logic                            done,
	output logic [1:0]                      status,
	output logic [swl_pkg::TOTAL_FIELD_W-1:0] window_total,
	output logic                            rd_en,
	output logic [IDX_W-1:0]                rd_addr,
	input  logic [swl_pkg::TIME_W+swl_pkg::WEIGHT_W-1:0] rd_data,
	output logic                            wr_en,
	output logic [IDX_W-1:0]                wr_addr,
	output logic [swl_pkg::TIME_W+swl_pkg::WEIGHT_W-1:0] wr_data
);

	localparam int TOT_W = $clog2(LOG_ENTRIES * 255 + 1);
	localparam int CMP_W = ((TOT_W > swl_pkg::LIMIT_W) ? TOT_W : swl_pkg::LIMIT_W) + 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LOG_ENTRIES - 1);

	swl_pkg::state_t state_q, state_d;

	logic [swl_pkg::TIME_W-1:0]   now_q;
	logic [swl_pkg::WEIGHT_W-1:0] w_q;
	logic [IDX_W-1:0]             cnt_q;
	logic [TOT_W-1:0]             total_q;
	logic                         free_found_q;
	logic [IDX_W-1:0]             free_idx_q;
	logic [LOG_ENTRIES-1:0]       valid_q;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic                         done_q;
	swl_pkg::status_t             status_q;
	logic [swl_pkg::TOTAL_FIELD_W-1:0] total_out_q;

	logic [swl_pkg::TIME_W-1:0]   rd_time;
	logic [swl_pkg::WEIGHT_W-1:0] rd_weight;
	logic [swl_pkg::TIME_W-1:0]   age;
	logic                         expired;
	logic [CMP_W-1:0]             total_ext;
	logic                         over_limit;
	swl_pkg::status_t             status_d;

	assign rd_time   = rd_data[swl_pkg::TIME_W+swl_pkg::WEIGHT_W-1:swl_pkg::WEIGHT_W];
	assign rd_weight = rd_data[swl_pkg::WEIGHT_W-1:0];
	// Age wraps modulo 2^32, so entries that look ahead of now expire unless the window covers the wrapped age.
	assign age       = now_q - rd_time;
	assign expired   = age > cfg.window_ms;

	assign total_ext  = CMP_W'(total_q);
	assign over_limit = (total_ext + CMP_W'(w_q)) > CMP_W'(cfg.weight_limit);

	always_comb begin
		if (over_limit) begin
			status_d = swl_pkg::ST_OVER_LIMIT;
		end else if (!free_found_q) begin
			status_d = swl_pkg::ST_LOG_FULL;
		end else begin
			status_d = swl_pkg::ST_ALLOWED;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			swl_pkg::S_IDLE: begin
				if (start) state_d = swl_pkg::S_SCAN;
			end
			swl_pkg::S_SCAN: begin
				if (cnt_q == LAST_IDX) state_d = swl_pkg::S_LAST;
			end
			swl_pkg::S_LAST:   state_d = swl_pkg::S_DECIDE;
			swl_pkg::S_DECIDE: state_d = swl_pkg::S_IDLE;
			default:           state_d = swl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy    = (state_q != swl_pkg::S_IDLE);
	assign rd_en   = (state_q == swl_pkg::S_SCAN);
	assign rd_addr = cnt_q;
	assign wr_en   = (state_q == swl_pkg::S_DECIDE) && (status_d == swl_pkg::ST_ALLOWED);
	assign wr_addr = free_idx_q;
	assign wr_data = {now_q, w_q};

	// Control flops: valid bits, read tracking, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == swl_pkg::S_SCAN);
			done_q    <= (state_q == swl_pkg::S_DECIDE);
			if (rd_vld_s1 && valid_q[idx_s1] && expired) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (wr_en) begin
				valid_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// Datapath: latch the transaction, accumulate over the sweep, register the result.
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		if (state_q == swl_pkg::S_IDLE && start) begin
			now_q        <= now_ms;
			w_q          <= weight;
			cnt_q        <= '0;
			total_q      <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end
		if (state_q == swl_pkg::S_SCAN && cnt_q != LAST_IDX) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (rd_vld_s1) begin
			if (valid_q[idx_s1] && !expired) begin
				total_q <= total_q + TOT_W'(rd_weight);
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
		if (state_q == swl_pkg::S_DECIDE) begin
			status_q <= status_d;
			if (total_ext > CMP_W'(swl_pkg::TOTAL_FIELD_MAX)) begin
				total_out_q <= swl_pkg::TOTAL_FIELD_W'(swl_pkg::TOTAL_FIELD_MAX);
			end else begin
				total_out_q <= total_ext[swl_pkg::TOTAL_FIELD_W-1:0];
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign window_total = total_out_q;

endmodule

>>> src/sliding_window_weight_limiter_core.sv
// Top level of the sliding-window weight limiter: configuration registers,
// log RAM and scan sequencer. Depends on swl_pkg, swl_log_mem and swl_ctrl.
//
//   channel   signals                                     transfer
//   request   start, busy, now_ms, weight                 start && !busy
//   result    done, status, window_total                  done (one cycle)
//   config    cfg_we, cfg_index, cfg_wdata                cfg_we
//
// A request is accepted into S_SCAN, where the sweep reads one log slot per cycle
// through the single RAM read port; S_LAST then takes the last registered read data
// and S_DECIDE decides and logs.
// The strobe shows in the first idle cycle, where a new start is taken.
// Reset empties the log at once through per-slot valid flops; no clearing pass.
// Results cannot be stalled; configuration writes take effect on the next edge.
module sliding_window_weight_limiter_core #(
	parameter int LOG_ENTRIES = swl_pkg::LOG_ENTRIES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [swl_pkg::TIME_W-1:0]          now_ms,
	input  logic [swl_pkg::WEIGHT_W-1:0]        weight,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [swl_pkg::TOTAL_FIELD_W-1:0]   window_total,
	input  logic                                cfg_we,
	input  logic [swl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swl_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int IDX_W = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
	localparam int DW    = swl_pkg::TIME_W + swl_pkg::WEIGHT_W;

	swl_pkg::cfg_t cfg_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [DW-1:0]    rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [DW-1:0]    wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_limit <= swl_pkg::LIMIT_RESET;
			cfg_q.window_ms    <= swl_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			case (swl_pkg::cfg_reg_t'(cfg_index))
				swl_pkg::REG_WEIGHT_LIMIT:
					cfg_q.weight_limit <= cfg_wdata[swl_pkg::LIMIT_W-1:0];
				swl_pkg::REG_WINDOW_MS:
					cfg_q.window_ms <= cfg_wdata[swl_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	swl_log_mem #(
		.DEPTH (LOG_ENTRIES),
		.AW    (IDX_W),
		.DW    (DW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	swl_ctrl #(
		.LOG_ENTRIES (LOG_ENTRIES),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.start        (start),
		.busy         (busy),
		.now_ms       (now_ms),
		.weight       (weight),
		.done         (done),
		.status       (status),
		.window_total (window_total),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data)
	);

endmodule

>>> src/swl_checker.sv
// Port-level checks for the sliding-window weight limiter, bound to the top.
// Depends on swl_pkg and sliding_window_weight_limiter_core.
module swl_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [1:0]                        status,
	input logic [swl_pkg::TOTAL_FIELD_W-1:0] window_total
);

	// An accepted transaction occupies the block on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not raise busy");

	// The result strobe comes only as the block returns to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done outside the end of a transaction");

	// Strobe is a single-cycle pulse.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// Only defined status codes are reported.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == swl_pkg::ST_ALLOWED || status == swl_pkg::ST_OVER_LIMIT ||
			status == swl_pkg::ST_LOG_FULL))
		else $error("undefined status code");

	// Allowed never shows a saturated total: 16 default slots hold at most 4080.
	a_allowed_total: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == swl_pkg::ST_ALLOWED) |->
			(window_total != swl_pkg::TOTAL_FIELD_W'(swl_pkg::TOTAL_FIELD_MAX)))
		else $error("allowed with saturated window total");

endmodule

bind sliding_window_weight_limiter_core swl_checker u_swl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.window_total (window_total)
);

>>> test/sliding_window_weight_limiter_core_tb.sv
// Self-checking bench for sliding_window_weight_limiter_core: directed table, then random phases.
// A local log model predicts status and window total; checked table rows carry their own.
// Depends on swl_pkg for widths, register indexes and status codes.
module sliding_window_weight_limiter_core_tb;

	localparam int  LOG_N      = swl_pkg::LOG_ENTRIES_DEF;
	localparam int  PHASES     = 8;
	localparam int  PHASE_REQS = 175;
	localparam int  PRINT_CAP  = 50;

	typedef struct packed {
		swl_pkg::status_t                   status;
		logic [swl_pkg::TOTAL_FIELD_W-1:0]  total;
	} verdict_t;

	typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [31:0] a;      // timestamp, or register index
		logic [31:0] b;      // weight, or register data
		bit         typed;
		verdict_t   want;
	} dir_row_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               start;
	logic                               busy;
	logic [swl_pkg::TIME_W-1:0]         now_ms;
	logic [swl_pkg::WEIGHT_W-1:0]       weight;
	logic                               done;
	logic [1:0]                         status;
	logic [swl_pkg::TOTAL_FIELD_W-1:0]  window_total;
	logic                               cfg_we;
	logic [swl_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [swl_pkg::CFG_DATA_W-1:0]     cfg_wdata;

	// local copy of the limiter state
	logic [swl_pkg::LIMIT_W-1:0]  limit_reg;
	logic [swl_pkg::TIME_W-1:0]   window_reg;
	logic                         slot_live [LOG_N];
	logic [swl_pkg::WEIGHT_W-1:0] slot_wt   [LOG_N];
	logic [swl_pkg::TIME_W-1:0]   slot_time [LOG_N];

	verdict_t   pending_verdicts [$];
	dir_row_t   dir_rows [$];
	bit         typed_pending;
	verdict_t   typed_verdict;
	verdict_t   got_v;
	verdict_t   seen_v;
	int         mismatches;

	sliding_window_weight_limiter_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.now_ms       (now_ms),
		.weight       (weight),
		.done         (done),
		.status       (status),
		.window_total (window_total),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #6 clk = ~clk;

	// Expire old entries, sum the rest, then log or refuse the request.
	function automatic verdict_t judge_request(logic [31:0] t, logic [7:0] w);
		verdict_t v;
		int sum;
		int free_slot;
		logic [31:0] age;
		sum = 0;
		free_slot = -1;
		for (int i = 0; i < LOG_N; i++) begin
			if (slot_live[i]) begin
				age = t - slot_time[i];
				if (age > window_reg)
					slot_live[i] = 1'b0;
			end
			if (slot_live[i])
				sum += slot_wt[i];
			else if (free_slot < 0)
				free_slot = i;
		end
		if (sum + int'(w) > int'(limit_reg)) begin
			v.status = swl_pkg::ST_OVER_LIMIT;
		end else if (free_slot < 0) begin
			v.status = swl_pkg::ST_LOG_FULL;
		end else begin
			slot_live[free_slot] = 1'b1;
			slot_wt[free_slot]   = w;
			slot_time[free_slot] = t;
			v.status = swl_pkg::ST_ALLOWED;
		end
		v.total = (sum > swl_pkg::TOTAL_FIELD_MAX) ?
			swl_pkg::TOTAL_FIELD_W'(swl_pkg::TOTAL_FIELD_MAX) : swl_pkg::TOTAL_FIELD_W'(sum);
		return v;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatches < PRINT_CAP)
			$display("%0t: %s mismatch: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Compare the strobed result first: it belongs to an earlier transaction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch("unrequested result, status", int'(status), -1);
			end else begin
				seen_v = pending_verdicts.pop_front();
				if (status !== seen_v.status)
					report_mismatch("status", int'(status), int'(seen_v.status));
				if (window_total !== seen_v.total)
					report_mismatch("window_total", int'(window_total), int'(seen_v.total));
			end
		end
		if (arst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
			got_v = judge_request(now_ms, weight);
			pending_verdicts.push_back(typed_pending ? typed_verdict : got_v);
		end
	end

	task automatic add_req(logic [31:0] t, logic [7:0] w);
		dir_row_t r;
		r.kind  = ROW_REQ;
		r.a     = t;
		r.b     = {24'd0, w};
		r.typed = 1'b0;
		r.want  = '0;
		dir_rows.push_back(r);
	endtask

	task automatic add_req_chk(logic [31:0] t, logic [7:0] w, swl_pkg::status_t st,
			logic [11:0] tot);
		dir_row_t r;
		r.kind         = ROW_REQ;
		r.a            = t;
		r.b            = {24'd0, w};
		r.typed        = 1'b1;
		r.want.status  = st;
		r.want.total   = tot;
		dir_rows.push_back(r);
	endtask

	task automatic add_cfg(swl_pkg::cfg_reg_t idx, logic [31:0] data);
		dir_row_t r;
		r.kind  = ROW_CFG;
		r.a     = {31'd0, idx};
		r.b     = data;
		r.typed = 1'b0;
		r.want  = '0;
		dir_rows.push_back(r);
	endtask

	// Hold the request until the block takes it.
	task automatic send_req(logic [31:0] t, logic [7:0] w, bit typed, verdict_t want);
		@(negedge clk);
		typed_pending = typed;
		typed_verdict = want;
		start  <= 1'b1;
		now_ms <= t;
		weight <= w;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(swl_pkg::cfg_reg_t idx, logic [31:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			swl_pkg::REG_WEIGHT_LIMIT: limit_reg  = data[swl_pkg::LIMIT_W-1:0];
			swl_pkg::REG_WINDOW_MS:    window_reg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic idle_after(int pct);
		int n;
		n = 0;
		if (pct == 0)
			return;
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(1, 24);
		else
			while (n < 40 && $urandom_range(0, 99) < pct)
				n++;
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int          idle_pct [PHASES];
		logic [31:0] lim_word;
		logic [31:0] win_word;
		logic [31:0] t;
		logic [31:0] step_max;
		logic [7:0]  w;
		int          roll;

		idle_pct = '{0, 62, 16, 0, 62, 16, 62, 0};
		arst_n    = 1'b0;
		start     = 1'b0;
		now_ms    = '0;
		weight    = '0;
		cfg_we    = 1'b0;
		cfg_index = swl_pkg::REG_WEIGHT_LIMIT;
		cfg_wdata = '0;
		typed_pending = 1'b0;
		typed_verdict = '0;
		mismatches    = 0;
		limit_reg  = swl_pkg::LIMIT_RESET;
		window_reg = swl_pkg::WINDOW_RESET;
		for (int i = 0; i < LOG_N; i++) begin
			slot_live[i] = 1'b0;
			slot_wt[i]   = '0;
			slot_time[i] = '0;
		end

		// reset values: limit 100, window 60000
		add_req_chk(32'd1000,  8'd0,   swl_pkg::ST_ALLOWED,    12'd0);
		add_req_chk(32'd1000,  8'd255, swl_pkg::ST_OVER_LIMIT, 12'd0);
		add_req_chk(32'd1000,  8'd100, swl_pkg::ST_ALLOWED,    12'd0);
		// age equal to the window keeps the entry
		add_req_chk(32'd61000, 8'd0,   swl_pkg::ST_ALLOWED,    12'd100);
		add_req_chk(32'd61001, 8'd1,   swl_pkg::ST_ALLOWED,    12'd0);
		// entry stamped ahead of now ages past the window and goes
		add_req_chk(32'd61000, 8'd0,   swl_pkg::ST_ALLOWED,    12'd0);
		add_cfg(swl_pkg::REG_WEIGHT_LIMIT, 32'hFFFF_FFFF);
		add_cfg(swl_pkg::REG_WINDOW_MS,    32'hFFFF_FFFF);
		for (int i = 0; i < 14; i++)
			add_req(32'd61000, 8'd255);
		add_req_chk(32'd0,     8'd255, swl_pkg::ST_LOG_FULL,   12'd3570);
		add_cfg(swl_pkg::REG_WEIGHT_LIMIT, 32'd3570);
		// over limit wins over a full log
		add_req_chk(32'd61000, 8'd1,   swl_pkg::ST_OVER_LIMIT, 12'd3570);
		add_cfg(swl_pkg::REG_WINDOW_MS,    32'd0);
		add_req_chk(32'd61000, 8'd7,   swl_pkg::ST_OVER_LIMIT, 12'd3570);
		add_req_chk(32'hFFFF_FFFF, 8'd255, swl_pkg::ST_ALLOWED, 12'd0);
		add_cfg(swl_pkg::REG_WEIGHT_LIMIT, 32'd0);
		add_req_chk(32'hFFFF_FFFF, 8'd0, swl_pkg::ST_OVER_LIMIT, 12'd255);
		add_cfg(swl_pkg::REG_WINDOW_MS,    32'd1);
		// age across the counter wrap
		add_req_chk(32'd0,     8'd0,   swl_pkg::ST_OVER_LIMIT, 12'd255);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_CFG) begin
				drain_results();
				write_reg(swl_pkg::cfg_reg_t'(dir_rows[k].a[0]), dir_rows[k].b);
			end else begin
				send_req(dir_rows[k].a, dir_rows[k].b[7:0], dir_rows[k].typed, dir_rows[k].want);
			end
		end
		typed_pending = 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			case (ph)
				0: begin lim_word = 32'd100;  win_word = 32'd60000; end
				1: begin
					lim_word = {16'($urandom_range(0, 65535)), 16'hFFFF};
					win_word = '1;
				end
				2: begin
					lim_word = {16'($urandom_range(0, 65535)), 16'h0000};
					win_word = '0;
				end
				3: begin lim_word = $urandom; win_word = $urandom_range(1, 5000); end
				4: begin lim_word = 32'd4080; win_word = 32'd1; end
				5: begin lim_word = $urandom_range(0, 600); win_word = $urandom; end
				6: begin lim_word = 32'd1000; win_word = 32'd500; end
				default: begin lim_word = $urandom; win_word = $urandom; end
			endcase
			write_reg(swl_pkg::REG_WEIGHT_LIMIT, lim_word);
			write_reg(swl_pkg::REG_WINDOW_MS, win_word);
			t = $urandom;
			step_max = (window_reg >> 2) + 32'd2;
			for (int n = 0; n < PHASE_REQS; n++) begin
				roll = $urandom_range(0, 99);
				// mostly a clock that moves forward; sometimes jump or step back
				if (roll < 8)
					t = $urandom;
				else if (roll < 12)
					t = t - $urandom_range(0, step_max);
				else
					t = t + $urandom_range(0, step_max);
				w = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 20));
				send_req(t, w, 1'b0, '0);
				if (ph == 6 && n == PHASE_REQS / 2)
					drain_results();
				idle_after(idle_pct[ph]);
			end
		end

		drain_results();
		repeat (LOG_N + 8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
src/swl_pkg.sv
src/swl_log_mem.sv
src/swl_ctrl.sv
src/sliding_window_weight_limiter_core.sv
src/swl_checker.sv
test/sliding_window_weight_limiter_core_tb.sv
